### sv/vaer_pkg.sv
package vaer_pkg;

   localparam int NUM_AXES     = 3;
   localparam int NUM_EXTREMES = 6;
   localparam int NUM_SLOTS    = NUM_AXES * NUM_EXTREMES;
   localparam int SLOT_W       = $clog2(NUM_SLOTS);
   localparam int AXIS_W       = $clog2(NUM_AXES);
   localparam int VERT_W       = $clog2(NUM_EXTREMES);
   localparam int QUEUE_DEPTH  = 2;

endpackage

### sv/vaer_front.sv
module vaer_front #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                accept,
   input  logic [COORD_WIDTH-1:0]                              vertex_x,
   input  logic [COORD_WIDTH-1:0]                              vertex_y,
   input  logic [COORD_WIDTH-1:0]                              vertex_z,
   input  logic                                                last_vertex,
   output logic                                                snap_push,
   output logic [vaer_pkg::NUM_SLOTS-1:0][COORD_WIDTH-1:0]     snap_data
);
   import vaer_pkg::*;

   logic [NUM_SLOTS-1:0][COORD_WIDTH-1:0] extreme_ff;
   logic [NUM_SLOTS-1:0][COORD_WIDTH-1:0] extreme_in;
   logic                                  started_ff;
   logic                                  started_in;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  vtx;
   logic [NUM_EXTREMES-1:0]               take;

   always_comb begin
      logic [COORD_WIDTH-1:0] held;
      vtx[0]     = vertex_x;
      vtx[1]     = vertex_y;
      vtx[2]     = vertex_z;
      extreme_in = extreme_ff;
      for (int e = 0; e < NUM_EXTREMES; e++) begin
         held = extreme_ff[e * NUM_AXES + (e >> 1)];
         if ((e & 1) != 0) begin
            take[e] = !started_ff || ($signed(vtx[e >> 1]) > $signed(held));
         end else begin
            take[e] = !started_ff || ($signed(vtx[e >> 1]) < $signed(held));
         end
         if (take[e]) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               extreme_in[e * NUM_AXES + a] = vtx[a];
            end
         end
      end
      started_in = !last_vertex;
   end

   assign snap_push = accept && last_vertex;
   assign snap_data = extreme_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else if (accept) begin
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         extreme_ff <= extreme_in;
      end
   end

endmodule

### sv/vaer_queue.sv
module vaer_queue #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            push,
   input  logic [vaer_pkg::NUM_SLOTS-1:0][COORD_WIDTH-1:0] wr_data,
   output logic                                            full,
   input  logic                                            pop,
   output logic                                            empty,
   output logic [vaer_pkg::NUM_SLOTS-1:0][COORD_WIDTH-1:0] rd_data
);
   import vaer_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [NUM_SLOTS-1:0][COORD_WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]                      wr_ptr_ff;
   logic [PTR_W-1:0]                      wr_ptr_in;
   logic [PTR_W-1:0]                      rd_ptr_ff;
   logic [PTR_W-1:0]                      rd_ptr_in;
   logic [CNT_W-1:0]                      count_ff;
   logic [CNT_W-1:0]                      count_in;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### sv/vaer_back.sv
module vaer_back #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            snap_empty,
   input  logic [vaer_pkg::NUM_SLOTS-1:0][COORD_WIDTH-1:0] snap_data,
   output logic                                            snap_pop,
   input  logic                                            pop,
   output logic                                            empty,
   output logic [COORD_WIDTH-1:0]                          x_extent,
   output logic [COORD_WIDTH-1:0]                          y_extent,
   output logic [COORD_WIDTH-1:0]                          z_extent,
   output logic [COORD_WIDTH-1:0]                          max_radius,
   output logic                                            origin_outside
);
   import vaer_pkg::*;

   localparam int SQ_W  = 2 * COORD_WIDTH;
   localparam int REM_W = COORD_WIDTH + 2;
   localparam int CNT_W = $clog2(COORD_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_FLUSH,
      ST_ROOT,
      ST_DONE
   } state_type;

   state_type                             state_ff, state_in;
   logic [NUM_SLOTS-1:0][COORD_WIDTH-1:0] snap_ff, snap_in;
   logic [AXIS_W-1:0]                     iss_axis_ff, iss_axis_in;
   logic [VERT_W-1:0]                     iss_vert_ff, iss_vert_in;
   logic                                  pr_valid_ff, pr_valid_in;
   logic [AXIS_W-1:0]                     pr_axis_ff, pr_axis_in;
   logic [SQ_W-1:0]                       prod_ff, prod_in;
   logic [SQ_W-1:0]                       acc_ff, acc_in;
   logic [SQ_W-1:0]                       best_ff, best_in;
   logic [SQ_W-1:0]                       n_ff, n_in;
   logic [REM_W-1:0]                      rem_ff, rem_in;
   logic [COORD_WIDTH-1:0]                root_ff, root_in;
   logic [CNT_W-1:0]                      cnt_ff, cnt_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  ext_ff, ext_in;
   logic [COORD_WIDTH-1:0]                radius_ff, radius_in;
   logic                                  outside_ff, outside_in;

   logic [SLOT_W-1:0]                     slot;
   logic [COORD_WIDTH-1:0]                coord;
   logic [COORD_WIDTH-1:0]                mag;
   logic [SQ_W-1:0]                       sum;
   logic [REM_W+1:0]                      rem_wide;
   logic [REM_W+1:0]                      trial;
   logic                                  ge;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  span;
   logic                                  outside_any;

   // spans and origin test straight from the held snapshot
   always_comb begin
      logic [COORD_WIDTH-1:0] lo;
      logic [COORD_WIDTH-1:0] hi;
      outside_any = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         lo      = snap_ff[(2 * a) * NUM_AXES + a];
         hi      = snap_ff[(2 * a + 1) * NUM_AXES + a];
         span[a] = hi - lo;
         if ($signed(lo) > 0 || $signed(hi) < 0) begin
            outside_any = 1'b1;
         end
      end
   end

   assign slot     = SLOT_W'(iss_vert_ff) * SLOT_W'(NUM_AXES) + SLOT_W'(iss_axis_ff);
   assign coord    = snap_ff[slot];
   assign mag      = coord[COORD_WIDTH-1] ? (~coord + 1'b1) : coord;
   assign sum      = (pr_axis_ff == '0) ? prod_ff : acc_ff + prod_ff;
   assign rem_wide = {rem_ff, n_ff[SQ_W-1 -: 2]};
   assign trial    = {2'b00, root_ff, 2'b01};
   assign ge       = (rem_wide >= trial);

   always_comb begin
      state_in     = state_ff;
      snap_in      = snap_ff;
      iss_axis_in  = iss_axis_ff;
      iss_vert_in  = iss_vert_ff;
      pr_valid_in  = 1'b0;
      pr_axis_in   = pr_axis_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      n_in         = n_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      ext_in       = ext_ff;
      radius_in    = radius_ff;
      outside_in   = outside_ff;
      snap_pop     = 1'b0;

      if (pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end

      // accumulate squared length per vertex, keep the largest
      if (pr_valid_ff) begin
         acc_in = sum;
         if (pr_axis_ff == AXIS_W'(NUM_AXES - 1) && sum > best_ff) begin
            best_in = sum;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (!snap_empty) begin
               snap_in     = snap_data;
               snap_pop    = 1'b1;
               iss_axis_in = '0;
               iss_vert_in = '0;
               best_in     = '0;
               state_in    = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            prod_in     = mag * mag;
            pr_axis_in  = iss_axis_ff;
            pr_valid_in = 1'b1;
            if (iss_axis_ff == AXIS_W'(NUM_AXES - 1)) begin
               iss_axis_in = '0;
               iss_vert_in = iss_vert_ff + 1'b1;
               if (iss_vert_ff == VERT_W'(NUM_EXTREMES - 1)) begin
                  state_in = ST_FLUSH;
               end
            end else begin
               iss_axis_in = iss_axis_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            n_in     = best_in;
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            // one root bit per cycle, two radicand bits consumed
            n_in    = {n_ff[SQ_W-3:0], 2'b00};
            root_in = {root_ff[COORD_WIDTH-2:0], ge};
            rem_in  = ge ? REM_W'(rem_wide - trial) : rem_wide[REM_W-1:0];
            if (cnt_ff == CNT_W'(COORD_WIDTH - 1)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || pop) begin
               ext_in       = span;
               radius_in    = root_ff;
               outside_in   = outside_any;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pr_valid_ff  <= pr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      snap_ff     <= snap_in;
      iss_axis_ff <= iss_axis_in;
      iss_vert_ff <= iss_vert_in;
      pr_axis_ff  <= pr_axis_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      best_ff     <= best_in;
      n_ff        <= n_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      cnt_ff      <= cnt_in;
      ext_ff      <= ext_in;
      radius_ff   <= radius_in;
      outside_ff  <= outside_in;
   end

   assign empty          = !rsp_valid_ff;
   assign x_extent       = ext_ff[0];
   assign y_extent       = ext_ff[1];
   assign z_extent       = ext_ff[2];
   assign max_radius     = radius_ff;
   assign origin_outside = outside_ff;

endmodule

### sv/vertex_extents_and_radius_core.sv
// channel   direction  handshake             word
// req       in         push / full           req_vertex_x/y/z, req_last_vertex
// rsp       out        empty / pop           rsp_x/y/z_extent, rsp_max_radius,
//                                            rsp_origin_outside
//
// One vertex per cycle while full is low; extremes update in the cycle the vertex is taken.
// A mesh result appears once its last vertex has passed the queue, the shared
// squarer (18 coordinates, one a cycle) and the one-bit-a-cycle root.
// Two finished meshes queue between front and back; full rises while both wait.
// Reset is synchronous: clears the queue, the pending result and the mesh start.
module vertex_extents_and_radius_core #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [COORD_WIDTH-1:0] req_vertex_x,
   input  logic [COORD_WIDTH-1:0] req_vertex_y,
   input  logic [COORD_WIDTH-1:0] req_vertex_z,
   input  logic                   req_last_vertex,
   output logic                   empty,
   input  logic                   pop,
   output logic [COORD_WIDTH-1:0] rsp_x_extent,
   output logic [COORD_WIDTH-1:0] rsp_y_extent,
   output logic [COORD_WIDTH-1:0] rsp_z_extent,
   output logic [COORD_WIDTH-1:0] rsp_max_radius,
   output logic                   rsp_origin_outside
);
   import vaer_pkg::*;

   logic                                  accept;
   logic                                  snap_push;
   logic [NUM_SLOTS-1:0][COORD_WIDTH-1:0] snap_wr;
   logic [NUM_SLOTS-1:0][COORD_WIDTH-1:0] snap_rd;
   logic                                  snap_empty;
   logic                                  snap_pop;

   assign accept = push && !full;

   vaer_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .vertex_x    (req_vertex_x),
      .vertex_y    (req_vertex_y),
      .vertex_z    (req_vertex_z),
      .last_vertex (req_last_vertex),
      .snap_push   (snap_push),
      .snap_data   (snap_wr)
   );

   vaer_queue #(.COORD_WIDTH(COORD_WIDTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (snap_push),
      .wr_data (snap_wr),
      .full    (full),
      .pop     (snap_pop),
      .empty   (snap_empty),
      .rd_data (snap_rd)
   );

   vaer_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .snap_empty     (snap_empty),
      .snap_data      (snap_rd),
      .snap_pop       (snap_pop),
      .pop            (pop),
      .empty          (empty),
      .x_extent       (rsp_x_extent),
      .y_extent       (rsp_y_extent),
      .z_extent       (rsp_z_extent),
      .max_radius     (rsp_max_radius),
      .origin_outside (rsp_origin_outside)
   );

endmodule

### sv/vaer_checker.sv
module vaer_checker #(
   parameter int COORD_WIDTH = 24
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   push,
   input logic                   full,
   input logic [COORD_WIDTH-1:0] req_vertex_x,
   input logic [COORD_WIDTH-1:0] req_vertex_y,
   input logic [COORD_WIDTH-1:0] req_vertex_z,
   input logic                   req_last_vertex,
   input logic                   empty,
   input logic                   pop,
   input logic [COORD_WIDTH-1:0] rsp_x_extent,
   input logic [COORD_WIDTH-1:0] rsp_y_extent,
   input logic [COORD_WIDTH-1:0] rsp_z_extent,
   input logic [COORD_WIDTH-1:0] rsp_max_radius,
   input logic                   rsp_origin_outside
);

   // a waiting word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_x_extent) && $stable(rsp_y_extent)
         && $stable(rsp_z_extent) && $stable(rsp_max_radius)
         && $stable(rsp_origin_outside)))
      else $error("result word changed while waiting");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (empty && !full))
      else $error("queues not clear after reset");

   // every span is covered by twice the radius of the extreme vertices
   a_radius_x: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ({1'b0, rsp_x_extent} <= {rsp_max_radius, 1'b0}))
      else $error("x span exceeds twice the radius");

   a_radius_y: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ({1'b0, rsp_y_extent} <= {rsp_max_radius, 1'b0}))
      else $error("y span exceeds twice the radius");

   a_radius_z: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ({1'b0, rsp_z_extent} <= {rsp_max_radius, 1'b0}))
      else $error("z span exceeds twice the radius");

endmodule

bind vertex_extents_and_radius_core vaer_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (.*);

### verif/vertex_extents_and_radius_core_checker.sv
`timescale 1ns / 1ps

module vertex_extents_and_radius_core_checker #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  logic [COORD_WIDTH-1:0] req_vertex_x,
   input  logic [COORD_WIDTH-1:0] req_vertex_y,
   input  logic [COORD_WIDTH-1:0] req_vertex_z,
   input  logic                   req_last_vertex,
   input  logic                   empty,
   input  logic                   pop,
   input  logic [COORD_WIDTH-1:0] rsp_x_extent,
   input  logic [COORD_WIDTH-1:0] rsp_y_extent,
   input  logic [COORD_WIDTH-1:0] rsp_z_extent,
   input  logic [COORD_WIDTH-1:0] rsp_max_radius,
   input  logic                   rsp_origin_outside,
   output int                     fail_count,
   output int                     meshes_due
);
   import vaer_pkg::*;

   typedef struct {
      logic [COORD_WIDTH-1:0] x_extent;
      logic [COORD_WIDTH-1:0] y_extent;
      logic [COORD_WIDTH-1:0] z_extent;
      logic [COORD_WIDTH-1:0] max_radius;
      logic                   origin_outside;
   } mesh_summary_type;

   // x, y, z of least-x, greatest-x, least-y, greatest-y, least-z, greatest-z
   logic signed [COORD_WIDTH-1:0] corner [NUM_SLOTS];
   logic                          mesh_open;
   mesh_summary_type              summaries_due [$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic absorb_vertex(input logic signed [COORD_WIDTH-1:0] vx, vy, vz,
                                input logic last);
      logic signed [COORD_WIDTH-1:0] v [NUM_AXES];
      logic signed [COORD_WIDTH-1:0] held, lo, hi;
      mesh_summary_type              s;
      longint                        c, sq, best;
      longint                        root, trial;
      int                            axis;
      v[0] = vx;
      v[1] = vy;
      v[2] = vz;
      for (int e = 0; e < NUM_EXTREMES; e++) begin
         axis = e / 2;
         held = corner[e * NUM_AXES + axis];
         if (!mesh_open || ((e % 2 == 1) ? (v[axis] > held) : (v[axis] < held))) begin
            for (int a = 0; a < NUM_AXES; a++)
               corner[e * NUM_AXES + a] = v[a];
         end
      end
      mesh_open = 1'b1;
      if (!last)
         return;
      s.origin_outside = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         lo = corner[(2 * a) * NUM_AXES + a];
         hi = corner[(2 * a + 1) * NUM_AXES + a];
         if (lo > 0 || hi < 0)
            s.origin_outside = 1'b1;
         case (a)
            0: s.x_extent = hi - lo;
            1: s.y_extent = hi - lo;
            default: s.z_extent = hi - lo;
         endcase
      end
      best = 0;
      for (int e = 0; e < NUM_EXTREMES; e++) begin
         sq = 0;
         for (int a = 0; a < NUM_AXES; a++) begin
            c = corner[e * NUM_AXES + a];
            sq += c * c;
         end
         if (sq > best)
            best = sq;
      end
      root = 0;
      for (int b = 25; b >= 0; b--) begin
         trial = root | (64'sd1 <<< b);
         if (trial * trial <= best)
            root = trial;
      end
      s.max_radius = root[COORD_WIDTH-1:0];
      summaries_due.insert(summaries_due.size(), s);
      mesh_open = 1'b0;
   endtask

   always @(posedge clock) begin
      mesh_summary_type want;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++)
            corner[i] = '0;
         mesh_open = 1'b0;
         summaries_due.delete();
      end else begin
         if (pop && !empty) begin
            if (summaries_due.size() == 0) begin
               report_mismatch("word with nothing due", 64'(rsp_max_radius), '0);
            end else begin
               want = summaries_due.pop_front();
               if (rsp_x_extent !== want.x_extent)
                  report_mismatch("x_extent", 64'(rsp_x_extent), 64'(want.x_extent));
               if (rsp_y_extent !== want.y_extent)
                  report_mismatch("y_extent", 64'(rsp_y_extent), 64'(want.y_extent));
               if (rsp_z_extent !== want.z_extent)
                  report_mismatch("z_extent", 64'(rsp_z_extent), 64'(want.z_extent));
               if (rsp_max_radius !== want.max_radius)
                  report_mismatch("max_radius", 64'(rsp_max_radius),
                                  64'(want.max_radius));
               if (rsp_origin_outside !== want.origin_outside)
                  report_mismatch("origin_outside", 64'(rsp_origin_outside),
                                  64'(want.origin_outside));
            end
         end
         if (push && !full)
            absorb_vertex(req_vertex_x, req_vertex_y, req_vertex_z, req_last_vertex);
      end
      meshes_due = summaries_due.size();
   end

endmodule

### verif/vertex_extents_and_radius_core_test.sv
`timescale 1ns / 1ps

module vertex_extents_and_radius_core_test;

   localparam int                     W         = 24;
   localparam int                     LATENCY   = W + 21;
   localparam int                     NUM_ITEMS = 1150;
   localparam logic [W-1:0]           C_MIN     = 24'h800000;
   localparam logic [W-1:0]           C_MAX     = 24'h7FFFFF;
   localparam logic [W-1:0]           C_NEG1    = 24'hFFFFFF;

   logic         clock = 1'b0;
   logic         reset;
   logic         push;
   logic         full;
   logic [W-1:0] req_vertex_x;
   logic [W-1:0] req_vertex_y;
   logic [W-1:0] req_vertex_z;
   logic         req_last_vertex;
   logic         empty;
   logic         pop = 1'b0;
   logic [W-1:0] rsp_x_extent;
   logic [W-1:0] rsp_y_extent;
   logic [W-1:0] rsp_z_extent;
   logic [W-1:0] rsp_max_radius;
   logic         rsp_origin_outside;
   logic         steady = 1'b0;
   int           fail_count;
   int           meshes_due;
   int           sent;

   always #5 clock = ~clock;

   vertex_extents_and_radius_core #(.COORD_WIDTH(W)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_vertex_x       (req_vertex_x),
      .req_vertex_y       (req_vertex_y),
      .req_vertex_z       (req_vertex_z),
      .req_last_vertex    (req_last_vertex),
      .empty              (empty),
      .pop                (pop),
      .rsp_x_extent       (rsp_x_extent),
      .rsp_y_extent       (rsp_y_extent),
      .rsp_z_extent       (rsp_z_extent),
      .rsp_max_radius     (rsp_max_radius),
      .rsp_origin_outside (rsp_origin_outside)
   );

   vertex_extents_and_radius_core_checker #(.COORD_WIDTH(W)) u_checker (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_vertex_x       (req_vertex_x),
      .req_vertex_y       (req_vertex_y),
      .req_vertex_z       (req_vertex_z),
      .req_last_vertex    (req_last_vertex),
      .empty              (empty),
      .pop                (pop),
      .rsp_x_extent       (rsp_x_extent),
      .rsp_y_extent       (rsp_y_extent),
      .rsp_z_extent       (rsp_z_extent),
      .rsp_max_radius     (rsp_max_radius),
      .rsp_origin_outside (rsp_origin_outside),
      .fail_count         (fail_count),
      .meshes_due         (meshes_due)
   );

   always @(negedge clock) begin
      pop <= steady || ($urandom_range(99) >= 7);
   end

   // push stays high across back-to-back words; lowered only while idle cycles are inserted
   task automatic send_vertex(input logic [W-1:0] vx, vy, vz, input logic last);
      steady = (sent >= 500 && sent < 800);
      while (!steady && $urandom_range(99) < 7) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push            <= 1'b1;
      req_vertex_x    <= vx;
      req_vertex_y    <= vy;
      req_vertex_z    <= vz;
      req_last_vertex <= last;
      do @(posedge clock); while (full);
      @(negedge clock);
      sent++;
   endtask

   function automatic logic [W-1:0] pick_coord(input int style);
      logic [W-1:0] r;
      case (style)
         0: r = W'($urandom);
         1: r = W'(int'($urandom_range(16)) - 8);
         2: begin
            case ($urandom_range(4))
               0: r = C_MIN;
               1: r = C_MAX;
               2: r = '0;
               3: r = C_NEG1;
               default: r = W'(1);
            endcase
         end
         default: r = W'(int'($urandom_range(131072)) - 65536);
      endcase
      return r;
   endfunction

   initial begin
      int           mesh_len;
      int           style;
      logic [W-1:0] px, py, pz;
      reset           = 1'b1;
      push            = 1'b0;
      req_vertex_x    = '0;
      req_vertex_y    = '0;
      req_vertex_z    = '0;
      req_last_vertex = 1'b0;
      sent            = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // single-vertex meshes at zero and at the extremes
      send_vertex('0, '0, '0, 1'b1);
      send_vertex(C_MAX, C_MAX, C_MAX, 1'b1);
      send_vertex(C_MIN, C_MIN, C_MIN, 1'b1);
      // full-scale spans
      send_vertex(C_MIN, C_MAX, '0, 1'b0);
      send_vertex(C_MAX, C_MIN, '0, 1'b0);
      send_vertex('0, '0, C_MIN, 1'b0);
      send_vertex('0, '0, C_MAX, 1'b1);
      // ties keep the first extreme
      send_vertex(24'd5, '0, '0, 1'b0);
      send_vertex(24'd5, 24'd7, 24'd7, 1'b0);
      send_vertex(24'd5, -24'sd7, -24'sd7, 1'b1);
      // zero on the boundary counts as inside
      send_vertex('0, 24'd3, 24'd3, 1'b0);
      send_vertex(24'd4, '0, -24'sd2, 1'b0);
      send_vertex(24'd2, 24'd5, '0, 1'b1);
      // least above zero
      send_vertex(24'd1, 24'd1, 24'd1, 1'b0);
      send_vertex(24'd2, 24'd2, C_NEG1, 1'b1);
      // greatest below zero
      send_vertex(C_NEG1, -24'sd5, 24'd2, 1'b0);
      send_vertex(-24'sd3, 24'd4, -24'sd2, 1'b1);

      while (sent < NUM_ITEMS) begin
         case ($urandom_range(19))
            0:       mesh_len = 1;
            1, 2, 3: mesh_len = $urandom_range(40, 17);
            default: mesh_len = $urandom_range(16, 1);
         endcase
         style = $urandom_range(3);
         px = pick_coord(style);
         py = pick_coord(style);
         pz = pick_coord(style);
         for (int i = 0; i < mesh_len; i++) begin
            if ($urandom_range(9) != 0) begin
               if ($urandom_range(3) == 0)
                  px = pick_coord(style);
               else
                  px = ($urandom_range(1) == 0) ? px : pick_coord($urandom_range(3));
               py = ($urandom_range(4) == 0) ? py : pick_coord(style);
               pz = ($urandom_range(4) == 0) ? pz : pick_coord(style);
            end
            send_vertex(px, py, pz, i == mesh_len - 1);
         end
      end
      push <= 1'b0;

      while (meshes_due != 0) @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (fail_count == 0)
         $display("PASS vertex_extents_and_radius_core");
      else
         $display("FAIL vertex_extents_and_radius_core");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL vertex_extents_and_radius_core");
      $finish;
   end

endmodule
